// File: sv/khht_pkg.sv
// ----------------------------------------------------------------------------
// khht_pkg: shared types and constants for the keyed handle hash table
// Geometry of the bucket store, word codes, and the bucket index function.
// ----------------------------------------------------------------------------
package khht_pkg;

    localparam int BUCKETS    = 64;
    localparam int WAYS       = 4;
    localparam int VALUE_BITS = 32;

    localparam int SLOTS  = BUCKETS * WAYS;
    localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int KEY_W  = 16;
    localparam int OUT_W  = 32;
    localparam int ECNT_W = 9;

    // bucket = key mod BUCKETS
    localparam bit            BKT_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
    localparam logic [15:0]   KEY_MASK = 16'(BUCKETS - 1);
    localparam logic [32:0]   RECIP    = 33'((64'd1 << 32) / BUCKETS);

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STS_DONE = 2'd0,
        STS_NO   = 2'd1,
        STS_FULL = 2'd2,
        STS_RSVD = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_BUSY = 1'b1
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]      key;
        logic [VALUE_BITS-1:0] handler;
        logic [VALUE_BITS-1:0] env;
    } entry_t;

    typedef entry_t [WAYS-1:0] row_t;

    // outcome of one word against its bucket
    typedef struct packed {
        status_t          status;
        logic             wr_row;     // insert into a free way
        logic             clr_valid;  // remove of a present key
        logic             hit;        // lookup hit
        logic [WAY_W-1:0] way;        // free way on insert, hit way otherwise
    } plan_t;

    function automatic logic [BKT_W-1:0] bucket_of(input logic [15:0] k);
        logic [48:0] prod;
        logic [15:0] q;
        logic [31:0] qd;
        logic [15:0] rem;
        prod = 49'(k) * 49'(RECIP);
        q    = prod[47:32];
        qd   = 32'(q) * 32'(BUCKETS);
        rem  = k - qd[15:0];
        if (rem >= 16'(BUCKETS)) begin
            rem = rem - 16'(BUCKETS);
        end
        if (BKT_POW2) begin
            rem = k & KEY_MASK;
        end
        return BKT_W'(rem);
    endfunction

endpackage

// File: sv/keyed_handle_hash_table.sv
// ----------------------------------------------------------------------------
// keyed_handle_hash_table: key-to-handle map with fixed-way buckets
// Insert, remove and lookup of 16-bit keys; each word reads one bucket row
// and an insert writes it back. Every result carries the live entry count.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata (low bit up)                     | tuser
//  --------+-----+----------------------------------------+---------------
//  s_      | in  | key[15:0] handler[47:16] env[79:48]    | action[1:0]
//  m_      | out | handler[31:0] env[63:32] count[72:64]  | status[1:0]
//
//  Each word passes idle then busy: the accept in idle issues the bucket row
//  read from the single-port row memory; the busy state compares the ways,
//  writes the row back and loads the output register. One word is in flight.
//  Reset clears all valid bits (flip-flops), the count and the output valid
//  at once; no clearing pass. Key, handler and env rows need no reset.
//  A stalled result holds the block in its busy state; a new word is
//  taken while the previous result still waits in the output register.
//
module keyed_handle_hash_table
    import khht_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // key, handler_value, env_value
    input  logic [79:0] s_tdata,
    // action
    input  logic [1:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // handler_out, env_out, entry_count, zero pad
    output logic [79:0] m_tdata,
    // status
    output logic [1:0]  m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready
);

    // ---------------- input word fields
    logic [KEY_W-1:0] s_key;
    logic [31:0]      s_handler;
    logic [31:0]      s_env;

    assign s_key     = s_tdata[15:0];
    assign s_handler = s_tdata[47:16];
    assign s_env     = s_tdata[79:48];

    // ---------------- control
    state_t state_reg, state_next;
    logic   accept;
    logic   commit;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (!m_tvalid || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        commit   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_BUSY: begin
                // output slot free or being drained this cycle
                commit = !m_tvalid || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- captured word
    action_t               act_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [VALUE_BITS-1:0] hv_reg;
    logic [VALUE_BITS-1:0] ev_reg;
    logic [BKT_W-1:0]      bkt_reg;
    logic [BKT_W-1:0]      bkt_in;

    assign bkt_in = bucket_of(s_key);

    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg <= action_t'(s_tuser);
            key_reg <= s_key;
            hv_reg  <= VALUE_BITS'(s_handler);
            ev_reg  <= VALUE_BITS'(s_env);
            bkt_reg <= bkt_in;
        end
    end

    // ---------------- bucket row memory, registered read
    row_t  row_mem [BUCKETS];
    row_t  rd_row_reg;
    row_t  wr_row;
    logic  mem_we;
    plan_t plan;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            row_mem[bkt_reg] <= wr_row;
        end
        if (accept) begin
            rd_row_reg <= row_mem[bkt_in];
        end
    end

    // ---------------- valid bits in flops, read with the row
    logic [WAYS-1:0] valid_reg [BUCKETS];
    logic [WAYS-1:0] valid_rd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int b = 0; b < BUCKETS; b++) begin
                valid_reg[b] <= '0;
            end
        end else if (commit) begin
            if (plan.wr_row) begin
                valid_reg[bkt_reg][plan.way] <= 1'b1;
            end else if (plan.clr_valid) begin
                valid_reg[bkt_reg][plan.way] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            valid_rd_reg <= valid_reg[bkt_in];
        end
    end

    // ---------------- compare ways
    khht_way_match u_match (
        .act   (act_reg),
        .key   (key_reg),
        .valid (valid_rd_reg),
        .row   (rd_row_reg),
        .plan  (plan)
    );

    // write back the row with the new entry in its free way
    always_comb begin
        wr_row                  = rd_row_reg;
        wr_row[plan.way].key     = key_reg;
        wr_row[plan.way].handler = hv_reg;
        wr_row[plan.way].env     = ev_reg;
    end

    assign mem_we = commit && plan.wr_row;

    // ---------------- entry count
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        count_next = count_reg;
        if (plan.wr_row) begin
            count_next = count_reg + CNT_W'(1);
        end else if (plan.clr_valid && (count_reg != '0)) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (commit) begin
            count_reg <= count_next;
        end
    end

    // ---------------- output register
    logic              m_valid_reg, m_valid_next;
    status_t           status_reg;
    logic [OUT_W-1:0]  hout_reg;
    logic [OUT_W-1:0]  eout_reg;
    logic [ECNT_W-1:0] ecnt_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            status_reg <= plan.status;
            hout_reg   <= plan.hit ? OUT_W'(rd_row_reg[plan.way].handler) : '0;
            eout_reg   <= plan.hit ? OUT_W'(rd_row_reg[plan.way].env) : '0;
            ecnt_reg   <= ECNT_W'(count_next);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {7'd0, ecnt_reg, eout_reg, hout_reg};

endmodule

// File: sv/khht_way_match.sv
// ----------------------------------------------------------------------------
// khht_way_match: way compare and decision for one bucket
// Finds the key among the valid ways, picks the lowest free way, and
// decides status and the update for the word's action.
// ----------------------------------------------------------------------------
module khht_way_match
    import khht_pkg::*;
(
    input  action_t          act,
    input  logic [KEY_W-1:0] key,
    input  logic [WAYS-1:0]  valid,
    input  row_t             row,
    output plan_t            plan
);

    logic [WAYS-1:0]  hitv;
    logic             any_hit;
    logic             any_free;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] free_way;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            hitv[w] = valid[w] && (row[w].key == key);
        end
    end

    // lowest way wins: scan from the top down
    always_comb begin
        any_hit  = 1'b0;
        any_free = 1'b0;
        hit_way  = '0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (hitv[w]) begin
                any_hit = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!valid[w]) begin
                any_free = 1'b1;
                free_way = WAY_W'(w);
            end
        end
    end

    always_comb begin
        plan.status    = STS_NO;
        plan.wr_row    = 1'b0;
        plan.clr_valid = 1'b0;
        plan.hit       = 1'b0;
        plan.way       = hit_way;
        case (act)
            ACT_INSERT: begin
                if (any_hit) begin
                    plan.status = STS_NO;
                end else if (any_free) begin
                    plan.status = STS_DONE;
                    plan.wr_row = 1'b1;
                    plan.way    = free_way;
                end else begin
                    plan.status = STS_FULL;
                end
            end
            ACT_REMOVE: begin
                if (any_hit) begin
                    plan.status    = STS_DONE;
                    plan.clr_valid = 1'b1;
                end
            end
            ACT_LOOKUP: begin
                if (any_hit) begin
                    plan.status = STS_DONE;
                    plan.hit    = 1'b1;
                end
            end
            default: begin
                plan.status = STS_NO;
            end
        endcase
    end

endmodule

// File: sv/khht_checker.sv
// ----------------------------------------------------------------------------
// khht_checker: port-level checks for keyed_handle_hash_table
// Watches both channels; bound to the top level below.
// ----------------------------------------------------------------------------
module khht_checker
    import khht_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [79:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tvalid,
    input logic        m_tready
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // one word in flight: ready drops after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while one is in flight");

    // handles come back only on a successful lookup
    a_handles_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STS_DONE) |-> (m_tdata[63:0] == 64'd0))
        else $error("nonzero handles on a miss or failed update");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser != STS_RSVD))
        else $error("reserved status code");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind keyed_handle_hash_table khht_checker u_khht_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
